// ----- hw/rtl/ust_pkg.sv -----
// Shared types, constants and helper functions of the UV-sphere cell tessellator.
`default_nettype none
package ust_pkg;

    // Segment counts above this value are clamped to it.
    localparam int MAX_SEGMENTS     = 256;
    localparam int CORDIC_STEPS_DEF = 16;

    // Internal CORDIC word: Q2.30 with headroom.
    localparam int CW = 34;

    localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic [31:0]          PI_Q30   = 32'd3373259426;

    localparam int CFG_IDX_W = 3;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LAT_COUNT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LON_COUNT = 3'd5;

    localparam logic [2:0] LAST_CORNER = 3'd5;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic [30:0]        sphere_radius;
        logic [8:0]         lat_count;
        logic [8:0]         lon_count;
    } t_cfg;

    // One classified cell as it waits in the queue.
    typedef struct packed {
        logic [7:0] lat_cell;
        logic [7:0] lon_cell;
        logic       bad_cell;
    } t_cell;

    typedef enum logic [2:0] {
        ANG_IDLE,
        ANG_DIV,
        ANG_ZMUL,
        ANG_ROT,
        ANG_DONE
    } t_ang_state;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_ANG,
        BK_MUL,
        BK_EMIT,
        BK_BAD
    } t_back_state;

    // Effective segment count: zero counts as one, large counts clamp.
    function automatic logic [8:0] eff_count(input logic [8:0] c);
        logic [8:0] r;
        if (c == 9'd0) begin
            r = 9'd1;
        end else if (32'(c) > MAX_SEGMENTS) begin
            r = 9'(MAX_SEGMENTS);
        end else begin
            r = c;
        end
        return r;
    endfunction

    // Arctangent of 2^-i in Q2.30.
    function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] i);
        logic signed [CW-1:0] r;
        case (i)
            5'd0:  r = 34'sd843314856;
            5'd1:  r = 34'sd497837829;
            5'd2:  r = 34'sd263043836;
            5'd3:  r = 34'sd133525158;
            5'd4:  r = 34'sd67021686;
            5'd5:  r = 34'sd33543515;
            5'd6:  r = 34'sd16775850;
            5'd7:  r = 34'sd8388437;
            5'd8:  r = 34'sd4194282;
            5'd9:  r = 34'sd2097149;
            5'd10: r = 34'sd1048575;
            5'd11: r = 34'sd524287;
            5'd12: r = 34'sd262143;
            5'd13: r = 34'sd131071;
            5'd14: r = 34'sd65535;
            5'd15: r = 34'sd32767;
            5'd16: r = 34'sd16383;
            5'd17: r = 34'sd8191;
            5'd18: r = 34'sd4095;
            5'd19: r = 34'sd2047;
            5'd20: r = 34'sd1023;
            5'd21: r = 34'sd511;
            5'd22: r = 34'sd255;
            5'd23: r = 34'sd127;
            5'd24: r = 34'sd63;
            5'd25: r = 34'sd31;
            5'd26: r = 34'sd15;
            5'd27: r = 34'sd8;
            5'd28: r = 34'sd4;
            5'd29: r = 34'sd2;
            5'd30: r = 34'sd1;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

    // Grid vertex shown at each corner of the run: v0, v2, v1, v1, v2, v3.
    function automatic logic [1:0] vert_of_corner(input logic [2:0] k);
        logic [1:0] r;
        case (k)
            3'd0:    r = 2'd0;
            3'd1:    r = 2'd2;
            3'd2:    r = 2'd1;
            3'd3:    r = 2'd1;
            3'd4:    r = 2'd2;
            default: r = 2'd3;
        endcase
        return r;
    endfunction

    // Clamp to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -36'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/ust_if.sv -----
// Channel interfaces: cell input, vertex output and configuration write.
`default_nettype none
interface ust_cell_if;
    logic       valid;
    logic       ready;
    logic [7:0] lat_cell;
    logic [7:0] lon_cell;
    modport source (output valid, lat_cell, lon_cell, input ready);
    modport sink   (input valid, lat_cell, lon_cell, output ready);
endinterface

interface ust_vert_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [2:0]         corner;
    logic               bad_cell;
    logic               last;
    modport source (output valid, pos_x, pos_y, pos_z, corner, bad_cell, last, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, corner, bad_cell, last, output ready);
endinterface

interface ust_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/ust_fifo.sv -----
// Two-entry queue between the classifying front and the computing back.
`default_nettype none
module ust_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_valid,
    output logic          o_wr_ready,
    input  ust_pkg::t_cell i_wr_data,
    output logic          o_rd_valid,
    input  logic          i_rd_ready,
    output ust_pkg::t_cell o_rd_data
);
    import ust_pkg::*;

    t_cell      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       wr_en;
    logic       rd_en;

    assign o_wr_ready = (r_cnt != 2'd2);
    assign o_rd_valid = (r_cnt != 2'd0);
    assign o_rd_data  = r_mem[r_rp];
    assign wr_en      = i_wr_valid && o_wr_ready;
    assign rd_en      = o_rd_valid && i_rd_ready;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_wr_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wp <= ~r_wp;
            end
            if (rd_en) begin
                r_rp <= ~r_rp;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/ust_front.sv -----
// Front end: takes cell transactions and marks cells outside the grid.
`default_nettype none
module ust_front (
    ust_cell_if.sink       i_cell,
    input  logic [8:0]     i_lat_count,
    input  logic [8:0]     i_lon_count,
    output logic           o_wr_valid,
    input  logic           i_wr_ready,
    output ust_pkg::t_cell o_wr_data
);
    import ust_pkg::*;

    logic [8:0] lat_eff;
    logic [8:0] lon_eff;

    assign lat_eff = eff_count(i_lat_count);
    assign lon_eff = eff_count(i_lon_count);

    // Classification against the configured grid.
    always_comb begin
        o_wr_data.lat_cell = i_cell.lat_cell;
        o_wr_data.lon_cell = i_cell.lon_cell;
        o_wr_data.bad_cell = ({1'b0, i_cell.lat_cell} >= lat_eff) ||
                             ({1'b0, i_cell.lon_cell} >= lon_eff);
    end

    assign o_wr_valid   = i_cell.valid;
    assign i_cell.ready = i_wr_ready;
endmodule
`default_nettype wire

// ----- hw/rtl/ust_angle.sv -----
// Angle unit: bit-serial divider to a turn fraction, then an iterative CORDIC.
`default_nettype none
module ust_angle #(
    parameter int CORDIC_STEPS = ust_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [8:0]         i_num,
    input  logic [9:0]         i_den,
    output logic               o_done,
    output logic signed [31:0] o_cos,
    output logic signed [31:0] o_sin
);
    import ust_pkg::*;

    localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [IW-1:0] LAST_STEP = IW'(CORDIC_STEPS - 1);

    t_ang_state r_state, n_state;

    logic [9:0]           r_rem;
    logic [9:0]           r_den;
    logic [31:0]          r_quo;
    logic [4:0]           r_dcnt;
    logic [IW-1:0]        r_icnt;
    logic [1:0]           r_quad;
    logic signed [CW-1:0] r_x, r_y, r_z;

    logic [10:0]          rem2;
    logic                 rem_ge;
    logic [61:0]          zprod;
    logic [4:0]           step_idx;
    logic signed [CW-1:0] dx, dy, atn;
    logic signed [CW-1:0] c_full, s_full;

    assign rem2     = {r_rem, 1'b0};
    assign rem_ge   = (rem2 >= {1'b0, r_den});
    assign zprod    = r_quo[29:0] * PI_Q30;
    assign step_idx = 5'(r_icnt);
    assign dx       = r_y >>> step_idx;
    assign dy       = r_x >>> step_idx;
    assign atn      = atan_q30(step_idx);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ANG_IDLE: if (i_start)              n_state = ANG_DIV;
            ANG_DIV:  if (r_dcnt == 5'd31)      n_state = ANG_ZMUL;
            ANG_ZMUL:                           n_state = ANG_ROT;
            ANG_ROT:  if (r_icnt == LAST_STEP)  n_state = ANG_DONE;
            ANG_DONE:                           n_state = ANG_IDLE;
            default:                            n_state = ANG_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ANG_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath: division one quotient bit a cycle, then one rotation a cycle.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ANG_IDLE: begin
                r_rem  <= {1'b0, i_num};
                r_den  <= i_den;
                r_quo  <= 32'd0;
                r_dcnt <= 5'd0;
            end
            ANG_DIV: begin
                r_rem  <= rem_ge ? 10'(rem2 - {1'b0, r_den}) : rem2[9:0];
                r_quo  <= {r_quo[30:0], rem_ge};
                r_dcnt <= r_dcnt + 5'd1;
            end
            ANG_ZMUL: begin
                r_quad <= r_quo[31:30];
                r_z    <= $signed({3'b000, zprod[61:31]});
                r_x    <= GAIN_Q30;
                r_y    <= '0;
                r_icnt <= '0;
            end
            ANG_ROT: begin
                if (!r_z[CW-1]) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - atn;
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + atn;
                end
                r_icnt <= r_icnt + 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Outputs: quadrant folding of the rotated vector.
    always_comb begin
        o_done = (r_state == ANG_DONE);
        case (r_quad)
            2'd0: begin c_full = r_x;  s_full = r_y;  end
            2'd1: begin c_full = -r_y; s_full = r_x;  end
            2'd2: begin c_full = -r_x; s_full = -r_y; end
            default: begin c_full = r_y; s_full = -r_x; end
        endcase
        o_cos = c_full[31:0];
        o_sin = s_full[31:0];
    end
endmodule
`default_nettype wire

// ----- hw/rtl/ust_back.sv -----
// Back end: works out the four grid points of a cell and sends its six vertices, or one bad-cell transaction.
`default_nettype none
module ust_back #(
    parameter int CORDIC_STEPS = ust_pkg::CORDIC_STEPS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ust_pkg::t_cfg  i_cfg,
    input  logic           i_valid,
    output logic           o_pop,
    input  ust_pkg::t_cell i_cell,
    ust_vert_if.source     o_vert
);
    import ust_pkg::*;

    t_back_state r_state, n_state;

    logic [7:0]         r_lat, r_lon;
    logic [2:0]         r_k;
    logic               r_issued;
    logic [1:0]         r_v;
    logic [2:0]         r_m;
    logic signed [31:0] r_cp [2], r_sp [2], r_ct [2], r_st [2];
    logic signed [31:0] r_t1, r_t2;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_vx [4], r_vy [4], r_vz [4];

    logic               r_ovalid;
    logic signed [31:0] r_px, r_py, r_pz;
    logic [2:0]         r_corner;
    logic               r_bad, r_last;

    logic               ang_start, ang_done;
    logic [8:0]         ang_num;
    logic [9:0]         ang_den;
    logic signed [31:0] ang_cos, ang_sin;
    logic [8:0]         lat_eff, lon_eff, lat_next, lon_next;
    logic               out_free, load_emit, load_bad;
    logic signed [31:0] mul_a, mul_b, rad_s;
    logic signed [63:0] rnd;
    logic signed [35:0] pos_sum;
    logic signed [31:0] org;
    logic [1:0]         vsel;

    ust_angle #(.CORDIC_STEPS(CORDIC_STEPS)) u_angle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ang_start),
        .i_num   (ang_num),
        .i_den   (ang_den),
        .o_done  (ang_done),
        .o_cos   (ang_cos),
        .o_sin   (ang_sin)
    );

    assign lat_eff  = eff_count(i_cfg.lat_count);
    assign lon_eff  = eff_count(i_cfg.lon_count);
    assign lat_next = {1'b0, r_lat} + 9'd1;
    // The seam point wraps to zero turns.
    assign lon_next = (({1'b0, r_lon} + 9'd1) == lon_eff) ? 9'd0 : {1'b0, r_lon} + 9'd1;

    // Angle operands: phi over 2L for the two latitudes, theta over M for the longitudes.
    always_comb begin
        case (r_k[1:0])
            2'd0:    ang_num = {1'b0, r_lat};
            2'd1:    ang_num = lat_next;
            2'd2:    ang_num = {1'b0, r_lon};
            default: ang_num = lon_next;
        endcase
        ang_den = r_k[1] ? {1'b0, lon_eff} : {lat_eff, 1'b0};
    end

    // Multiplier operand selection for the six-step vertex sequence.
    always_comb begin
        rad_s = $signed({1'b0, i_cfg.sphere_radius});
        case (r_m)
            3'd0:    begin mul_a = r_sp[r_v[1]]; mul_b = r_ct[r_v[0]]; end
            3'd1:    begin mul_a = r_sp[r_v[1]]; mul_b = r_st[r_v[0]]; end
            3'd2:    begin mul_a = rad_s;        mul_b = r_cp[r_v[1]]; end
            3'd3:    begin mul_a = rad_s;        mul_b = r_t1;         end
            default: begin mul_a = rad_s;        mul_b = r_t2;         end
        endcase
        rnd = (r_prod + 64'sd536870912) >>> 30;
        case (r_m)
            3'd3:    org = i_cfg.origin_y;
            3'd4:    org = i_cfg.origin_x;
            default: org = i_cfg.origin_z;
        endcase
        pos_sum = 36'(org) + 36'(rnd);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: if (i_valid) n_state = i_cell.bad_cell ? BK_BAD : BK_ANG;
            BK_ANG:  if (ang_done && r_k == 3'd3) n_state = BK_MUL;
            BK_MUL:  if (r_m == 3'd5 && r_v == 2'd3) n_state = BK_EMIT;
            BK_EMIT: if (out_free && r_k == LAST_CORNER) n_state = BK_IDLE;
            BK_BAD:  if (out_free) n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        out_free  = !r_ovalid || o_vert.ready;
        o_pop     = (r_state == BK_IDLE) && i_valid;
        ang_start = (r_state == BK_ANG) && !r_issued;
        load_emit = (r_state == BK_EMIT) && out_free;
        load_bad  = (r_state == BK_BAD) && out_free;
        vsel      = vert_of_corner(r_k);
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_k      <= 3'd0;
            r_issued <= 1'b0;
            r_v      <= 2'd0;
            r_m      <= 3'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_k      <= 3'd0;
                r_issued <= 1'b0;
            end
            if (ang_start) begin
                r_issued <= 1'b1;
            end
            if (r_state == BK_ANG && ang_done) begin
                r_issued <= 1'b0;
                r_k      <= (r_k == 3'd3) ? 3'd0 : r_k + 3'd1;
                r_v      <= 2'd0;
                r_m      <= 3'd0;
            end
            if (r_state == BK_MUL) begin
                if (r_m == 3'd5) begin
                    r_m <= 3'd0;
                    r_v <= r_v + 2'd1;
                end else begin
                    r_m <= r_m + 3'd1;
                end
            end
            if (load_emit) begin
                r_k <= r_k + 3'd1;
            end
            if (load_emit || load_bad) begin
                r_ovalid <= 1'b1;
            end else if (o_vert.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_lat <= i_cell.lat_cell;
            r_lon <= i_cell.lon_cell;
        end
        if (r_state == BK_ANG && ang_done) begin
            if (!r_k[1]) begin
                r_cp[r_k[0]] <= ang_cos;
                r_sp[r_k[0]] <= ang_sin;
            end else begin
                r_ct[r_k[0]] <= ang_cos;
                r_st[r_k[0]] <= ang_sin;
            end
        end
        if (r_state == BK_MUL) begin
            r_prod <= mul_a * mul_b;
            case (r_m)
                3'd1:    r_t1 <= rnd[31:0];
                3'd2:    r_t2 <= rnd[31:0];
                3'd3:    r_vy[r_v] <= sat32(pos_sum);
                3'd4:    r_vx[r_v] <= sat32(pos_sum);
                3'd5:    r_vz[r_v] <= sat32(pos_sum);
                default: begin
                end
            endcase
        end
        if (load_emit) begin
            r_px     <= r_vx[vsel];
            r_py     <= r_vy[vsel];
            r_pz     <= r_vz[vsel];
            r_corner <= r_k;
            r_bad    <= 1'b0;
            r_last   <= (r_k == LAST_CORNER);
        end else if (load_bad) begin
            r_px     <= '0;
            r_py     <= '0;
            r_pz     <= '0;
            r_corner <= 3'd0;
            r_bad    <= 1'b1;
            r_last   <= 1'b1;
        end
    end

    assign o_vert.valid    = r_ovalid;
    assign o_vert.pos_x    = r_px;
    assign o_vert.pos_y    = r_py;
    assign o_vert.pos_z    = r_pz;
    assign o_vert.corner   = r_corner;
    assign o_vert.bad_cell = r_bad;
    assign o_vert.last     = r_last;
endmodule
`default_nettype wire

// ----- hw/rtl/uv_sphere_cell_tessellator.sv -----
// Top level of the UV-sphere cell tessellator: configuration registers and the two halves.
// Each accepted cell yields six vertex transactions (v0, v2, v1, v1, v2, v3) with the
// corner index and last flag, or a single transaction with bad_cell set when the cell lies
// outside the configured grid. The four angles of a cell pass one after the other through
// a shared bit-serial divider and iterative CORDIC, and the vertex arithmetic then shares
// one multiplier. A two-entry queue lets new cells be taken while earlier ones are
// computed, and the output register holds a finished vertex while the next is prepared.
// Configuration writes are always taken and must be made while the block is idle.
`default_nettype none
module uv_sphere_cell_tessellator #(
    parameter int CORDIC_STEPS = ust_pkg::CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ust_cell_if.sink    i_cell,
    ust_vert_if.source  o_vert,
    ust_cfg_if.sink     i_cfg
);
    import ust_pkg::*;

    t_cfg  r_cfg;
    logic  wr_valid, wr_ready, rd_valid, rd_pop;
    t_cell wr_data, rd_data;

    // Configuration registers.
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x      <= '0;
            r_cfg.origin_y      <= '0;
            r_cfg.origin_z      <= '0;
            r_cfg.sphere_radius <= 31'd65536;
            r_cfg.lat_count     <= 9'd8;
            r_cfg.lon_count     <= 9'd8;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_ORIGIN_X:  r_cfg.origin_x      <= i_cfg.data;
                REG_ORIGIN_Y:  r_cfg.origin_y      <= i_cfg.data;
                REG_ORIGIN_Z:  r_cfg.origin_z      <= i_cfg.data;
                REG_RADIUS:    r_cfg.sphere_radius <= i_cfg.data[30:0];
                REG_LAT_COUNT: r_cfg.lat_count     <= i_cfg.data[8:0];
                REG_LON_COUNT: r_cfg.lon_count     <= i_cfg.data[8:0];
                default: begin
                end
            endcase
        end
    end

    ust_front u_front (
        .i_cell      (i_cell),
        .i_lat_count (r_cfg.lat_count),
        .i_lon_count (r_cfg.lon_count),
        .o_wr_valid  (wr_valid),
        .i_wr_ready  (wr_ready),
        .o_wr_data   (wr_data)
    );

    ust_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (wr_valid),
        .o_wr_ready (wr_ready),
        .i_wr_data  (wr_data),
        .o_rd_valid (rd_valid),
        .i_rd_ready (rd_pop),
        .o_rd_data  (rd_data)
    );

    ust_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (rd_valid),
        .o_pop   (rd_pop),
        .i_cell  (rd_data),
        .o_vert  (o_vert)
    );
endmodule
`default_nettype wire

// ----- hw/rtl/ust_checker.sv -----
// Port-level assertions for the tessellator and their binding to the top level.
`default_nettype none
module ust_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [31:0] i_pos_x,
    input logic [31:0] i_pos_y,
    input logic [31:0] i_pos_z,
    input logic [2:0]  i_corner,
    input logic        i_bad_cell,
    input logic        i_last
);
    // A stalled vertex transaction stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("vertex valid dropped while stalled");

    // A stalled vertex transaction keeps its payload.
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable({i_pos_x, i_pos_y, i_pos_z, i_corner,
                                         i_bad_cell, i_last}))
        else $error("vertex payload changed while stalled");

    // A bad cell is reported by one zeroed transaction that closes the run.
    a_bad_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_bad_cell |-> i_last && (i_corner == 3'd0) &&
            (i_pos_x == 32'd0) && (i_pos_y == 32'd0) && (i_pos_z == 32'd0))
        else $error("malformed bad-cell transaction");

    // In a good run the last flag sits on the sixth corner and nowhere else.
    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_bad_cell |-> (i_last == (i_corner == 3'd5)) && (i_corner <= 3'd5))
        else $error("last flag and corner disagree");
endmodule

bind uv_sphere_cell_tessellator ust_checker u_ust_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (o_vert.valid),
    .i_ready    (o_vert.ready),
    .i_pos_x    (o_vert.pos_x),
    .i_pos_y    (o_vert.pos_y),
    .i_pos_z    (o_vert.pos_z),
    .i_corner   (o_vert.corner),
    .i_bad_cell (o_vert.bad_cell),
    .i_last     (o_vert.last)
);
`default_nettype wire
